FILE: rtl/gmt_pkg.sv
package gmt_pkg;

    localparam int MAX_RESULTS = 32;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_REPORT = 2'd1;
    localparam logic [1:0] MODE_JOIN   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] EV_REMOVED = 3'd0;
    localparam logic [2:0] EV_GOSSIP  = 3'd1;
    localparam logic [2:0] EV_REPLY   = 3'd2;
    localparam logic [2:0] EV_ADDED   = 3'd3;
    localparam logic [2:0] EV_FULL    = 3'd4;

    localparam logic [1:0] CFG_OWN_ID          = 2'd0;
    localparam logic [1:0] CFG_OWN_PORT        = 2'd1;
    localparam logic [1:0] CFG_FAIL_TIMEOUT    = 2'd2;
    localparam logic [1:0] CFG_CLEANUP_TIMEOUT = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] tm;
    } entry_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] tm;
    } result_t;

endpackage

FILE: rtl/gmt_cell.sv
module gmt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  gmt_pkg::entry_t d,
    output gmt_pkg::entry_t q
);
    import gmt_pkg::*;

    logic        valid_reg;
    logic [15:0] id_reg;
    logic [15:0] port_reg;
    logic [31:0] hb_reg;
    logic [31:0] tm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    // payload follows the valid bit, no reset needed
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            id_reg   <= d.id;
            port_reg <= d.port;
            hb_reg   <= d.hb;
            tm_reg   <= d.tm;
        end
    end

    assign q = '{valid: valid_reg, id: id_reg, port: port_reg, hb: hb_reg, tm: tm_reg};

endmodule

FILE: rtl/gossip_membership_table.sv
// channel | signals                                          | direction
// in      | in_valid, in_ready, mode, member_id, member_port,| into block
//         | heartbeat                                        |
// out     | out_valid, out_ready, event_res, peer_id,        | out of block
//         | peer_port, peer_heartbeat, peer_time, last       |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | into block
//
// The table is a ring of TABLE_DEPTH cells that rotates one entry per cycle past
// the head cell unless stalled. A report or join makes a scan and an apply pass,
// a tick also an emit pass, then the finish state; each pass is one full turn
// of the ring. Reset empties the table and clears time and own heartbeat.
// The ring holds while the output register is full and not taken.
module gossip_membership_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] member_id,
    input  logic [15:0] member_port,
    input  logic [31:0] heartbeat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [15:0] peer_id,
    output logic [15:0] peer_port,
    output logic [31:0] peer_heartbeat,
    output logic [31:0] peer_time,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gmt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_EMIT,
        ST_FINISH
    } state_t;

    state_t      state_reg;
    logic [1:0]  mode_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic        match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic        free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [15:0] key_id_reg;
    logic [15:0] key_port_reg;
    logic [31:0] key_hb_reg;
    logic [31:0] time_reg;
    logic [31:0] own_hb_reg;
    logic [15:0] own_id_reg;
    logic [15:0] own_port_reg;
    logic [15:0] fail_to_reg;
    logic [15:0] cleanup_to_reg;
    logic        pend_valid_reg;
    result_t     pend_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_last_reg;

    entry_t cell_q [TABLE_DEPTH];
    entry_t tail_d;
    entry_t head;
    entry_t mod;
    logic   out_free;
    logic   step;
    logic   idx_last;
    logic   hit_match;
    logic   hit_free;
    logic   gen;
    logic   out_load;
    result_t gen_res;
    logic [31:0] age;
    logic [31:0] hb_inc;

    assign out_free = !out_valid_reg || out_ready;
    assign step = out_free &&
                  (state_reg == ST_SCAN || state_reg == ST_APPLY || state_reg == ST_EMIT);
    assign idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign head = cell_q[0];
    assign hb_inc = (own_hb_reg == 32'hFFFF_FFFF) ? own_hb_reg : own_hb_reg + 32'd1;
    assign out_load = pend_valid_reg &&
                      ((step && gen && cnt_reg < CNT_W'(MAX_RESULTS)) ||
                       (state_reg == ST_FINISH && out_free));

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_ring
        entry_t d_k;
        if (k == TABLE_DEPTH - 1)
        begin : g_tail
            assign d_k = tail_d;
        end
        else
        begin : g_mid
            assign d_k = cell_q[k + 1];
        end
        gmt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .shift(step),
            .d    (d_k),
            .q    (cell_q[k])
        );
    end

    always_comb
    begin
        mod       = head;
        gen       = 1'b0;
        gen_res   = '0;
        hit_match = head.valid && head.id == key_id_reg && head.port == key_port_reg;
        hit_free  = !head.valid;
        age       = '0;
        case (state_reg)
            ST_SCAN:
            begin
                if (idx_last && !(match_found_reg || hit_match))
                begin
                    gen         = 1'b1;
                    gen_res.ev  = (free_found_reg || hit_free) ? EV_ADDED : EV_FULL;
                    gen_res.id  = key_id_reg;
                    gen_res.port = key_port_reg;
                    gen_res.hb  = key_hb_reg;
                    gen_res.tm  = time_reg;
                end
            end
            ST_APPLY:
            begin
                if (match_found_reg && idx_reg == match_idx_reg &&
                    (mode_reg == MODE_TICK || head.hb < key_hb_reg))
                begin
                    mod.hb = key_hb_reg;
                    mod.tm = time_reg;
                end
                if (!match_found_reg && free_found_reg && idx_reg == free_idx_reg)
                begin
                    mod = '{valid: 1'b1, id: key_id_reg, port: key_port_reg,
                            hb: key_hb_reg, tm: time_reg};
                end
                age = time_reg - mod.tm;
                if (mode_reg == MODE_TICK)
                begin
                    if (mod.valid && age >= {16'd0, cleanup_to_reg})
                    begin
                        gen = 1'b1;
                        gen_res = '{ev: EV_REMOVED, id: mod.id, port: mod.port,
                                    hb: mod.hb, tm: mod.tm};
                        mod.valid = 1'b0;
                    end
                end
                else if (mode_reg == MODE_JOIN && mod.valid)
                begin
                    gen = 1'b1;
                    gen_res = '{ev: EV_REPLY, id: mod.id, port: mod.port,
                                hb: mod.hb, tm: mod.tm};
                end
            end
            ST_EMIT:
            begin
                age = time_reg - head.tm;
                if (head.valid && age < {16'd0, fail_to_reg})
                begin
                    gen = 1'b1;
                    gen_res = '{ev: EV_GOSSIP, id: head.id, port: head.port,
                                hb: head.hb, tm: head.tm};
                end
            end
            default:
            begin
                gen = 1'b0;
            end
        endcase
        tail_d = mod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_TICK;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            key_id_reg      <= '0;
            key_port_reg    <= '0;
            key_hb_reg      <= '0;
            time_reg        <= '0;
            own_hb_reg      <= '0;
            own_id_reg      <= 16'd1;
            own_port_reg    <= 16'd0;
            fail_to_reg     <= 16'd5;
            cleanup_to_reg  <= 16'd20;
            pend_valid_reg  <= 1'b0;
            pend_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_OWN_ID:          own_id_reg     <= cfg_data;
                    CFG_OWN_PORT:        own_port_reg   <= cfg_data;
                    CFG_FAIL_TIMEOUT:    fail_to_reg    <= cfg_data;
                    CFG_CLEANUP_TIMEOUT: cleanup_to_reg <= cfg_data;
                    default:             own_id_reg     <= own_id_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // hold the newest result back so the final one can carry last
            if (step && gen && cnt_reg < CNT_W'(MAX_RESULTS))
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (pend_valid_reg)
                begin
                    out_reg       <= pend_reg;
                    out_last_reg  <= 1'b0;
                end
                pend_reg       <= gen_res;
                pend_valid_reg <= 1'b1;
            end

            if (step)
            begin
                idx_reg <= idx_last ? '0 : idx_reg + IDX_W'(1);
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg        <= mode;
                        idx_reg         <= '0;
                        cnt_reg         <= '0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        case (mode)
                            MODE_TICK:
                            begin
                                time_reg     <= time_reg + 32'd1;
                                own_hb_reg   <= hb_inc;
                                key_id_reg   <= own_id_reg;
                                key_port_reg <= own_port_reg;
                                key_hb_reg   <= hb_inc;
                                state_reg    <= ST_SCAN;
                            end
                            MODE_REPORT, MODE_JOIN:
                            begin
                                key_id_reg   <= member_id;
                                key_port_reg <= member_port;
                                key_hb_reg   <= heartbeat;
                                state_reg    <= ST_SCAN;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (step)
                    begin
                        if (hit_match && !match_found_reg)
                        begin
                            match_found_reg <= 1'b1;
                            match_idx_reg   <= idx_reg;
                        end
                        if (hit_free && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                        if (idx_last)
                        begin
                            state_reg <= ST_APPLY;
                        end
                    end
                end
                ST_APPLY:
                begin
                    if (step && idx_last)
                    begin
                        state_reg <= (mode_reg == MODE_TICK) ? ST_EMIT : ST_FINISH;
                    end
                end
                ST_EMIT:
                begin
                    if (step && idx_last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg        <= pend_reg;
                            out_last_reg   <= 1'b1;
                            pend_valid_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign event_res      = out_reg.ev;
    assign peer_id        = out_reg.id;
    assign peer_port      = out_reg.port;
    assign peer_heartbeat = out_reg.hb;
    assign peer_time      = out_reg.tm;
    assign last           = out_last_reg;

endmodule
